// File: hw/rtl/flash_led_brightness_sequencer_core_macros.svh
// assertion macros for the flash led brightness sequencer core
// used by flash_led_brightness_sequencer_core.sv, expects clk and rst_n in scope
`ifndef FLASH_LED_BRIGHTNESS_SEQUENCER_CORE_MACROS_SVH
`define FLASH_LED_BRIGHTNESS_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FLBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flbs assertion failed");
`define FLBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flbs assertion failed");
`else
`define FLBS_ASSERT_IMP(label, ante, cons)
`define FLBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/flbs_pkg.sv
// types, constants and step tables of the flash led brightness sequencer
// no dependencies; imported by flash_led_brightness_sequencer_core
package flbs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_DIV   = 25;
    localparam int STEP_MAX   = 10;

    localparam logic [7:0] FULL_REQ = 8'hFF;
    localparam logic [3:0] OUT_BOTH = 4'h3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRE   = 2'd1,
        PH_FLASH = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_BRIGHT = 2'd0,
        CFG_PRE_MS     = 2'd1,
        CFG_FLASH_MS   = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_REQUEST = 1'b0,
        CMD_TICK    = 1'b1
    } cmd_t;

    localparam logic [4:0] STEP_RATIO [0:10] =
        '{5'd1, 5'd2, 5'd13, 5'd13, 5'd13, 5'd13, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16};
    localparam logic [4:0] STEP_LEVEL [0:10] =
        '{5'd1, 5'd2, 5'd3, 5'd9, 5'd13, 5'd16, 5'd13, 5'd10, 5'd12, 5'd14, 5'd16};

    // request / 25 clamped to 10, as a row of threshold compares
    function automatic logic [3:0] step_of(input logic [7:0] req);
        logic [3:0] s;
        s = '0;
        for (int i = 1; i <= STEP_MAX; i++)
        begin
            if (req >= 8'(STEP_DIV * i))
            begin
                s = 4'(i);
            end
        end
        return s;
    endfunction

    // (16 - x) mod 16
    function automatic logic [3:0] nib_of(input logic [4:0] x);
        logic [4:0] d;
        d = 5'd16 - x;
        return d[3:0];
    endfunction

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

endpackage

// File: hw/rtl/flash_led_brightness_sequencer_core.sv
// flash led brightness sequencer: request register, sequencing logic, result register
// depends on flbs_pkg and flash_led_brightness_sequencer_core_macros.svh
//
// usage:
//   input channel in_valid/in_stall carries command (0 request, 1 ms tick) and
//   brightness; a word is taken at a clock edge with in_valid high and in_stall low.
//   every input word yields exactly one result word on out_valid/out_stall with
//   enable_pin, flash_pin, reg_write, reg0_value, reg1_value and phase.
//   configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, index 0 preflash brightness, 1 preflash length,
//   2 flash length, 3 flash timeout. write only while the block is idle.
//   a word passes first into the request register and then into the
//   result register, which holds the word until out_stall is low.
//   throughput is one word per cycle unless out_stall holds it; the request register
//   and result register form a two-stage pipeline, so a new word is taken while a
//   result waits. while the receiver stalls, both stages fill, then in_stall rises.
//   reset clears the sequence to idle with enable and flash low, both stages
//   empty, and loads the configuration reset values.
`include "flash_led_brightness_sequencer_core_macros.svh"

module flash_led_brightness_sequencer_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [7:0]                     brightness,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           enable_pin,
    output logic                           flash_pin,
    output logic                           reg_write,
    output logic [7:0]                     reg0_value,
    output logic [7:0]                     reg1_value,
    output logic [1:0]                     phase,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [flbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [flbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import flbs_pkg::*;

    logic [7:0]  pre_bright_reg;
    logic [15:0] pre_ms_reg;
    logic [15:0] flash_ms_reg;
    logic [4:0]  timeout_reg;

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [7:0]  s1_bright_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] ms_reg, ms_next;
    logic [4:0]  level_reg, level_next;
    logic [4:0]  ratio_reg, ratio_next;
    logic        on_reg, on_next;
    logic        flash_reg, flash_next;
    logic        wrote_next;

    logic        out_valid_reg;
    logic        out_adv;
    logic        s1_fire;

    logic [7:0]  apply_req;
    logic        apply_en;
    logic [3:0]  step;
    logic [15:0] ms_dec;
    logic        seq_active;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_adv;
    assign in_stall  = s1_valid_reg && !out_adv;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_bright_reg <= 8'd200;
            pre_ms_reg     <= 16'd1000;
            flash_ms_reg   <= 16'd200;
            timeout_reg    <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRE_BRIGHT: pre_bright_reg <= cfg_data[7:0];
                CFG_PRE_MS:     pre_ms_reg     <= cfg_data[15:0];
                CFG_FLASH_MS:   flash_ms_reg   <= cfg_data[15:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_cmd_reg    <= command;
            s1_bright_reg <= brightness;
        end
    end

    // sequencing logic
    assign ms_dec     = (ms_reg != '0) ? ms_reg - 16'd1 : ms_reg;
    assign seq_active = phase_reg inside {PH_PRE, PH_FLASH};
    assign step       = step_of(apply_req);

    always_comb
    begin
        phase_next = phase_reg;
        ms_next    = ms_reg;
        flash_next = flash_reg;
        apply_req  = '0;
        apply_en   = 1'b0;
        if (cmd_t'(s1_cmd_reg) == CMD_REQUEST)
        begin
            apply_en = 1'b1;
            if (s1_bright_reg == FULL_REQ)
            begin
                apply_req  = pre_bright_reg;
                phase_next = PH_PRE;
                ms_next    = at_least_one(pre_ms_reg);
            end
            else
            begin
                apply_req  = s1_bright_reg;
                phase_next = PH_IDLE;
                ms_next    = '0;
            end
        end
        else if (seq_active)
        begin
            ms_next = ms_dec;
            if (ms_dec == '0)
            begin
                if (phase_reg == PH_PRE)
                begin
                    phase_next = PH_FLASH;
                    flash_next = 1'b1;
                    ms_next    = at_least_one(flash_ms_reg);
                end
                else
                begin
                    phase_next = PH_IDLE;
                    apply_en   = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        level_next = level_reg;
        ratio_next = ratio_reg;
        on_next    = on_reg;
        wrote_next = 1'b0;
        if (apply_en)
        begin
            level_next = STEP_LEVEL[step];
            ratio_next = STEP_RATIO[step];
            on_next    = (step != '0);
            wrote_next = (step != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ms_reg        <= '0;
            level_reg     <= 5'd1;
            ratio_reg     <= 5'd1;
            on_reg        <= 1'b0;
            flash_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                phase_reg <= phase_next;
                ms_reg    <= ms_next;
                level_reg <= level_next;
                ratio_reg <= ratio_next;
                on_reg    <= on_next;
                flash_reg <= apply_en ? 1'b0 : flash_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            enable_pin <= on_next;
            flash_pin  <= apply_en ? 1'b0 : flash_next;
            reg_write  <= wrote_next;
            reg0_value <= wrote_next ? {nib_of(level_next), nib_of(timeout_reg)} : 8'd0;
            reg1_value <= wrote_next ? {OUT_BOTH, nib_of(ratio_next)} : 8'd0;
            phase      <= phase_next;
        end
    end

    `FLBS_ASSERT_IMP(a_idle_count_zero, phase_reg == PH_IDLE, ms_reg == '0)
    `FLBS_ASSERT_IMP(a_write_needs_enable, out_valid && reg_write, enable_pin)
    `FLBS_ASSERT_IMP(a_flash_only_in_flash, out_valid && flash_pin, phase == PH_FLASH)
    `FLBS_ASSERT_NXT(a_stalled_word_kept, in_stall, s1_valid_reg)

endmodule

// File: test/tb_flash_led_brightness_sequencer_core.sv
// self-checking testbench for flash_led_brightness_sequencer_core: directed and random
// requests and ticks under random stalls, checked against an in-bench sequencer model
// depends on flbs_pkg and the core rtl
module tb_flash_led_brightness_sequencer_core;

    import flbs_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [4:0] RATIO_BY_STEP [0:10] =
        '{5'd1, 5'd2, 5'd13, 5'd13, 5'd13, 5'd13, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16};
    localparam logic [4:0] LEVEL_BY_STEP [0:10] =
        '{5'd1, 5'd2, 5'd3, 5'd9, 5'd13, 5'd16, 5'd13, 5'd10, 5'd12, 5'd14, 5'd16};

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] level_req;
    } led_req_t;

    typedef struct packed {
        logic       en;
        logic       fl;
        logic       wr;
        logic [7:0] r0;
        logic [7:0] r1;
        phase_t     ph;
    } led_word_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = 1'b0;
    logic [7:0]            brightness = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  enable_pin;
    logic                  flash_pin;
    logic                  reg_write;
    logic [7:0]            reg0_value;
    logic [7:0]            reg1_value;
    logic [1:0]            phase;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // sequencer model state and settings
    phase_t      sq_phase = PH_IDLE;
    logic [15:0] sq_left = '0;
    logic [4:0]  mv_level = 5'd1;
    logic [4:0]  fl_ratio = 5'd1;
    logic        led_on = 1'b0;
    logic        flash_on = 1'b0;
    logic [7:0]  cf_pre_bright = 8'd200;
    logic [15:0] cf_pre_ms = 16'd1000;
    logic [15:0] cf_flash_ms = 16'd200;
    logic [4:0]  cf_timeout = 5'd16;

    led_req_t  req_backlog [$];
    led_word_t led_words_due [$];
    led_req_t  next_req;
    led_word_t seen_word;
    led_word_t due_word;

    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   gap_pick;
    int   quiet_cycles = 0;
    int   n_bad = 0;
    logic calm_mode = 1'b0;
    logic [3:0] hold_req = '0;
    logic [3:0] hold_seen = '0;

    flash_led_brightness_sequencer_core i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .enable_pin (enable_pin),
        .flash_pin  (flash_pin),
        .reg_write  (reg_write),
        .reg0_value (reg0_value),
        .reg1_value (reg1_value),
        .phase      (phase),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_len(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic apply_level(input logic [7:0] req);
        int unsigned step;
        step = req / STEP_DIV;
        if (step > STEP_MAX)
        begin
            step = STEP_MAX;
        end
        fl_ratio = RATIO_BY_STEP[step];
        mv_level = LEVEL_BY_STEP[step];
        flash_on = 1'b0;
        led_on = (step != 0);
        return (step != 0);
    endfunction

    function automatic led_word_t predict_led_word(input cmd_t cmd, input logic [7:0] req);
        led_word_t w;
        logic      wrote;
        wrote = 1'b0;
        if (cmd == CMD_REQUEST)
        begin
            if (req == FULL_REQ)
            begin
                wrote = apply_level(cf_pre_bright);
                sq_phase = PH_PRE;
                sq_left = (cf_pre_ms == '0) ? 16'd1 : cf_pre_ms;
            end
            else
            begin
                sq_phase = PH_IDLE;
                sq_left = '0;
                wrote = apply_level(req);
            end
        end
        else if (sq_phase == PH_PRE || sq_phase == PH_FLASH)
        begin
            if (sq_left != '0)
            begin
                sq_left = sq_left - 16'd1;
            end
            if (sq_left == '0)
            begin
                if (sq_phase == PH_PRE)
                begin
                    sq_phase = PH_FLASH;
                    flash_on = 1'b1;
                    sq_left = (cf_flash_ms == '0) ? 16'd1 : cf_flash_ms;
                end
                else
                begin
                    sq_phase = PH_IDLE;
                    wrote = apply_level(8'd0);
                end
            end
        end
        w.en = led_on;
        w.fl = flash_on;
        w.wr = wrote;
        w.r0 = wrote ? {4'(5'd16 - mv_level), 4'(5'd16 - cf_timeout)} : 8'h00;
        w.r1 = wrote ? {OUT_BOTH, 4'(5'd16 - fl_ratio)} : 8'h00;
        w.ph = sq_phase;
        return w;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_REQUEST;
            brightness <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                led_words_due.push_back(predict_led_word(cmd_t'(command), brightness));
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    next_req = req_backlog.pop_front();
                    command <= next_req.cmd;
                    brightness <= next_req.level_req;
                    in_valid <= 1'b1;
                    send_gap <= idle_len(calm_mode);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_seen <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_word.en = enable_pin;
                seen_word.fl = flash_pin;
                seen_word.wr = reg_write;
                seen_word.r0 = reg0_value;
                seen_word.r1 = reg1_value;
                seen_word.ph = phase_t'(phase);
                if (led_words_due.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                    begin
                        $display("result word with none due: en=%0d fl=%0d wr=%0d r0=%02h r1=%02h ph=%0d",
                                 seen_word.en, seen_word.fl, seen_word.wr, seen_word.r0,
                                 seen_word.r1, seen_word.ph);
                    end
                end
                else
                begin
                    due_word = led_words_due.pop_front();
                    if (seen_word.en !== due_word.en || seen_word.fl !== due_word.fl ||
                        seen_word.wr !== due_word.wr || seen_word.r0 !== due_word.r0 ||
                        seen_word.r1 !== due_word.r1 || seen_word.ph !== due_word.ph)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("mismatch: exp en=%0d fl=%0d wr=%0d r0=%02h r1=%02h ph=%0d",
                                     due_word.en, due_word.fl, due_word.wr, due_word.r0,
                                     due_word.r1, due_word.ph);
                            $display("          got en=%0d fl=%0d wr=%0d r0=%02h r1=%02h ph=%0d",
                                     seen_word.en, seen_word.fl, seen_word.wr, seen_word.r0,
                                     seen_word.r1, seen_word.ph);
                        end
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                gap_pick = idle_len(calm_mode);
                out_stall <= (gap_pick != 0);
                stall_left <= (gap_pick == 0) ? 0 : gap_pick - 1;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_req(input cmd_t cmd, input logic [7:0] lvl);
        led_req_t q;
        q.cmd = cmd;
        q.level_req = lvl;
        req_backlog.push_back(q);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || in_valid || led_words_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PRE_BRIGHT: cf_pre_bright = data[7:0];
            CFG_PRE_MS:     cf_pre_ms = data;
            CFG_FLASH_MS:   cf_flash_ms = data;
            CFG_TIMEOUT:    cf_timeout = data[4:0];
            default:        ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] pb, input logic [15:0] pms,
                                 input logic [15:0] fms, input logic [4:0] tmo);
        write_cfg(CFG_PRE_BRIGHT, {8'h00, pb});
        write_cfg(CFG_PRE_MS, pms);
        write_cfg(CFG_FLASH_MS, fms);
        write_cfg(CFG_TIMEOUT, {11'h000, tmo});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_ms(input logic huge);
        int r;
        r = $urandom_range(0, 99);
        if (huge)
        begin
            return 16'hFFFF;
        end
        if (r < 15)
        begin
            return 16'd0;
        end
        if (r < 30)
        begin
            return 16'd1;
        end
        if (r < 80)
        begin
            return 16'($urandom_range(2, 12));
        end
        return 16'($urandom_range(13, 40));
    endfunction

    initial
    begin
        int unsigned dir_levels [14];
        int          p;
        int          n;
        int          k;
        int          i;
        int          r;
        logic [7:0]  pb;
        logic [15:0] pms;
        logic [15:0] fms;
        logic [4:0]  tmo;

        dir_levels = '{0, 24, 25, 50, 75, 100, 125, 150, 175, 200, 225, 249, 250, 254};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every step of the table, tick while idle, start, restart, cancel
        for (i = 0; i < 14; i++)
        begin
            queue_req(CMD_REQUEST, 8'(dir_levels[i]));
        end
        queue_req(CMD_TICK, 8'hFF);
        queue_req(CMD_REQUEST, FULL_REQ);
        queue_req(CMD_TICK, 8'h00);
        queue_req(CMD_REQUEST, FULL_REQ);
        queue_req(CMD_REQUEST, 8'd100);
        queue_req(CMD_TICK, 8'h5A);
        wait_drained();

        // zero lengths, full preflash level, shortest timeout
        load_settings(8'd255, 16'd0, 16'd0, 5'd1);
        queue_req(CMD_REQUEST, FULL_REQ);
        queue_req(CMD_TICK, 8'hA5);
        queue_req(CMD_TICK, 8'h0F);
        queue_req(CMD_TICK, 8'hF0);
        wait_drained();

        // dark preflash, wrapped timeout, short phases
        load_settings(8'd0, 16'd1, 16'd2, 5'd0);
        queue_req(CMD_REQUEST, FULL_REQ);
        queue_req(CMD_TICK, 8'h33);
        queue_req(CMD_TICK, 8'hCC);
        queue_req(CMD_REQUEST, 8'd7);
        wait_drained();

        for (p = 0; p < 13; p++)
        begin
            r = $urandom_range(0, 99);
            pb = (r < 12) ? 8'd0 : (r < 25) ? 8'd255 : (r < 35) ? 8'd254 : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            tmo = (r < 20) ? 5'd1 : (r < 40) ? 5'd16 : (r < 48) ? 5'd0 : (r < 55) ? 5'd31 :
                  5'($urandom_range(1, 16));
            pms = pick_ms(p == 6);
            fms = pick_ms(p == 6);
            load_settings(pb, pms, fms, tmo);
            calm_mode <= (p % 3 == 1);

            n = 0;
            while (n < 132)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    queue_req(CMD_REQUEST, FULL_REQ);
                    n++;
                    k = ((pms == '0) ? 1 : int'(pms)) + ((fms == '0) ? 1 : int'(fms)) +
                        $urandom_range(0, 2);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        k = $urandom_range(0, k);
                    end
                    if (k > 150)
                    begin
                        k = 150;
                    end
                    for (i = 0; i < k; i++)
                    begin
                        if ($urandom_range(0, 29) == 0)
                        begin
                            queue_req(CMD_REQUEST, 8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            queue_req(CMD_TICK, 8'($urandom));
                        end
                        n++;
                    end
                end
                else if (r < 85)
                begin
                    queue_req(CMD_REQUEST, 8'($urandom_range(0, 255)));
                    n++;
                end
                else
                begin
                    queue_req(CMD_TICK, 8'($urandom));
                    n++;
                end
            end
            queue_req(CMD_REQUEST, 8'($urandom_range(0, 254)));
            if (p == 2 || p == 9)
            begin
                hold_req <= hold_req + 4'd1;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_bad == 0 && led_words_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/flbs_pkg.sv
hw/rtl/flash_led_brightness_sequencer_core.sv
test/tb_flash_led_brightness_sequencer_core.sv
